@@ design/crcd_pkg.sv @@
// Shared types, constants and the CRC byte update for the chunk deframer.
package crcd_pkg;

	localparam logic [31:0] CRC_POLY = 32'h1edc6f41;
	localparam logic [31:0] MAGIC_ID = 32'h50534920;
	localparam logic [31:0] END_ID   = 32'h454e4420;

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// Byte classes
	localparam logic [1:0] CLS_HEADER  = 2'd0;
	localparam logic [1:0] CLS_PAYLOAD = 2'd1;
	localparam logic [1:0] CLS_CRC     = 2'd2;
	localparam logic [1:0] CLS_IGNORED = 2'd3;

	// Error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_BAD_MAGIC = 2'd1;
	localparam logic [1:0] ERR_CRC       = 2'd2;
	localparam logic [1:0] ERR_HALTED    = 2'd3;

	// Parser phase, one-hot
	typedef enum logic [3:0] {
		PH_HEADER  = 4'b0001,
		PH_PAYLOAD = 4'b0010,
		PH_CRC     = 4'b0100,
		PH_HALT    = 4'b1000
	} phase_t;

	// Classified byte, handed from front to back
	typedef struct packed {
		logic [1:0]  cls;
		logic [31:0] tag;
		logic [31:0] size;
		logic [31:0] rem;
		logic [7:0]  data;
		logic        done;
		logic        good;
		logic [1:0]  err;
		logic        img;
	} rec_t;

	// Shift one byte into the CRC, MSB first
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {b, 24'd0};
		for (int k = 0; k < 8; k++) begin
			if (r[31]) begin
				r = {r[30:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[30:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

@@ design/crc_checked_chunk_deframer.sv @@
// Top level of the CRC-checked chunk deframer.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  input   | in_valid / in_ready  | data_byte, new_image
//  output  | out_valid / out_ready| byte_class, chunk_tag, payload_offset,
//          |                      | payload_value, chunk_done, crc_good,
//          |                      | error_code, image_done
//
// One byte per cycle while the queue has room; each byte is registered in the queue, then in the output register.
// The parser front updates framing state and the 32-bit CRC on each accepted byte.
// A queue of QUEUE_DEPTH entries and the output register decouple the sides,
// so in_ready falls only when the queue fills behind a stalled output.
// Reset clears parser state and empties the queue; no clearing pass.
module crc_checked_chunk_deframer #(
	parameter int QUEUE_DEPTH = crcd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        new_image,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  byte_class,
	output logic [31:0] chunk_tag,
	output logic [31:0] payload_offset,
	output logic [7:0]  payload_value,
	output logic        chunk_done,
	output logic        crc_good,
	output logic [1:0]  error_code,
	output logic        image_done
);
	import crcd_pkg::*;

	localparam int RW = $bits(rec_t);

	rec_t          front_rec;
	rec_t          back_rec;
	logic          front_valid;
	logic          front_ready;
	logic          back_valid;
	logic          back_ready;
	logic [RW-1:0] push_data;
	logic [RW-1:0] pop_data;

	assign push_data = front_rec;
	assign back_rec  = rec_t'(pop_data);

	crcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.new_image (new_image),
		.rec_valid (front_valid),
		.rec_ready (front_ready),
		.rec       (front_rec)
	);

	crcd_fifo #(
		.WIDTH (RW),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (push_data),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (pop_data)
	);

	crcd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec_valid      (back_valid),
		.rec_ready      (back_ready),
		.rec            (back_rec),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.byte_class     (byte_class),
		.chunk_tag      (chunk_tag),
		.payload_offset (payload_offset),
		.payload_value  (payload_value),
		.chunk_done     (chunk_done),
		.crc_good       (crc_good),
		.error_code     (error_code),
		.image_done     (image_done)
	);

endmodule

@@ design/crcd_fifo.sv @@
// Short register queue between the parser front and the output back.
module crcd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [IW-1:0]    wr_ptr_q;
	logic [IW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Store entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IW'(DEPTH - 1)) ? '0 : wr_ptr_q + IW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IW'(DEPTH - 1)) ? '0 : rd_ptr_q + IW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ design/crcd_front.sv @@
// Parser front: tracks chunk framing and CRC, classifies each byte.
module crcd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    data_byte,
	input  logic          new_image,
	output logic          rec_valid,
	input  logic          rec_ready,
	output crcd_pkg::rec_t rec
);
	import crcd_pkg::*;

	phase_t      phase_q, phase_c, phase_n;
	logic [2:0]  count_q, count_c, count_n;
	logic [31:0] rem_q, rem_c, rem_n;
	logic [31:0] tag_q, tag_c, tag_n;
	logic [31:0] size_q, size_c, size_n;
	logic [31:0] crc_q, crc_c, crc_n;
	logic [31:0] stored_q, stored_c, stored_n;
	logic        first_q, first_c, first_n;
	logic [31:0] crc_upd;
	logic [31:0] size_sh;
	logic [31:0] stored_sh;
	logic        accept;

	assign in_ready  = rec_ready;
	assign rec_valid = in_valid;
	assign accept    = in_valid && rec_ready;

	// Restart on new image marker before parsing the byte
	always_comb begin
		phase_c  = new_image ? PH_HEADER : phase_q;
		count_c  = new_image ? 3'd0 : count_q;
		rem_c    = new_image ? 32'd0 : rem_q;
		tag_c    = new_image ? 32'd0 : tag_q;
		size_c   = new_image ? 32'd0 : size_q;
		crc_c    = new_image ? 32'd0 : crc_q;
		stored_c = new_image ? 32'd0 : stored_q;
		first_c  = new_image ? 1'b1 : first_q;
	end

	assign crc_upd   = crc_byte(crc_c, data_byte);
	assign size_sh   = {size_c[23:0], data_byte};
	assign stored_sh = {stored_c[23:0], data_byte};

	// Parse one byte
	always_comb begin
		phase_n  = phase_c;
		count_n  = count_c;
		rem_n    = rem_c;
		tag_n    = tag_c;
		size_n   = size_c;
		crc_n    = crc_c;
		stored_n = stored_c;
		first_n  = first_c;

		rec      = '0;
		rec.cls  = CLS_IGNORED;
		rec.err  = ERR_NONE;
		rec.tag  = tag_c;
		rec.size = size_c;
		rec.rem  = rem_c;
		rec.data = data_byte;

		case (phase_c)
			PH_HEADER: begin
				rec.cls = CLS_HEADER;
				crc_n   = crc_upd;
				if (!count_c[2]) begin
					tag_n = {tag_c[23:0], data_byte};
				end else begin
					size_n = size_sh;
				end
				if (count_c == 3'd7) begin
					count_n = 3'd0;
					if (first_c && tag_c != MAGIC_ID) begin
						rec.err = ERR_BAD_MAGIC;
						phase_n = PH_HALT;
					end else begin
						first_n  = 1'b0;
						rem_n    = size_sh;
						stored_n = 32'd0;
						phase_n  = (size_sh == 32'd0) ? PH_CRC : PH_PAYLOAD;
					end
				end else begin
					count_n = count_c + 3'd1;
				end
			end
			PH_PAYLOAD: begin
				rec.cls = CLS_PAYLOAD;
				crc_n   = crc_upd;
				rem_n   = rem_c - 32'd1;
				if (rem_c == 32'd1) begin
					count_n  = 3'd0;
					stored_n = 32'd0;
					phase_n  = PH_CRC;
				end
			end
			PH_CRC: begin
				rec.cls  = CLS_CRC;
				stored_n = stored_sh;
				if (count_c >= 3'd3) begin
					rec.done = 1'b1;
					count_n  = 3'd0;
					if (stored_sh == crc_c) begin
						rec.good = 1'b1;
						if (tag_c == END_ID) begin
							rec.img = 1'b1;
							phase_n = PH_HALT;
						end else begin
							phase_n = PH_HEADER;
							crc_n   = 32'd0;
							tag_n   = 32'd0;
							size_n  = 32'd0;
						end
					end else begin
						rec.err = ERR_CRC;
						phase_n = PH_HALT;
					end
				end else begin
					count_n = count_c + 3'd1;
				end
			end
			default: begin
				phase_n = PH_HALT;
				rec.err = ERR_HALTED;
			end
		endcase
	end

	// Hold parser state, update on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			count_q  <= 3'd0;
			rem_q    <= 32'd0;
			tag_q    <= 32'd0;
			size_q   <= 32'd0;
			crc_q    <= 32'd0;
			stored_q <= 32'd0;
			first_q  <= 1'b1;
		end else if (accept) begin
			phase_q  <= phase_n;
			count_q  <= count_n;
			rem_q    <= rem_n;
			tag_q    <= tag_n;
			size_q   <= size_n;
			crc_q    <= crc_n;
			stored_q <= stored_n;
			first_q  <= first_n;
		end
	end

endmodule

@@ design/crcd_back.sv @@
// Output back: forms result fields from a classified byte and holds them.
module crcd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rec_valid,
	output logic          rec_ready,
	input  crcd_pkg::rec_t rec,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    byte_class,
	output logic [31:0]   chunk_tag,
	output logic [31:0]   payload_offset,
	output logic [7:0]    payload_value,
	output logic          chunk_done,
	output logic          crc_good,
	output logic [1:0]    error_code,
	output logic          image_done
);
	import crcd_pkg::*;

	logic        valid_q;
	logic        load;
	logic        is_pay;
	logic        has_tag;
	logic [1:0]  cls_q;
	logic [31:0] tag_q;
	logic [31:0] off_q;
	logic [7:0]  val_q;
	logic        done_q;
	logic        good_q;
	logic [1:0]  err_q;
	logic        img_q;

	assign rec_ready = !valid_q || out_ready;
	assign load      = rec_valid && rec_ready;

	always_comb begin
		is_pay  = (rec.cls == CLS_PAYLOAD);
		has_tag = (rec.cls inside {CLS_PAYLOAD, CLS_CRC});
	end

	// Track output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rec_ready) begin
			valid_q <= rec_valid;
		end
	end

	// Load result fields, zero those that do not apply to the class
	always_ff @(posedge clk) begin
		if (load) begin
			cls_q  <= rec.cls;
			tag_q  <= has_tag ? rec.tag : 32'd0;
			off_q  <= is_pay ? (rec.size - rec.rem) : 32'd0;
			val_q  <= is_pay ? rec.data : 8'd0;
			done_q <= rec.done;
			good_q <= rec.good;
			err_q  <= rec.err;
			img_q  <= rec.img;
		end
	end

	assign out_valid      = valid_q;
	assign byte_class     = cls_q;
	assign chunk_tag      = tag_q;
	assign payload_offset = off_q;
	assign payload_value  = val_q;
	assign chunk_done     = done_q;
	assign crc_good       = good_q;
	assign error_code     = err_q;
	assign image_done     = img_q;

endmodule
